/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the scatter-accumulate checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SJSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SJSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sjsa_pkg.sv */
// ----------------------------------------------------------------------------
// sjsa_pkg
// Shared types and constants of the sparse Jacobian scatter-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package sjsa_pkg;

  localparam logic [1:0] MODE_RATE = 2'd0;
  localparam logic [1:0] MODE_INV  = 2'd1;
  localparam logic [1:0] MODE_TERM = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_RATE,
    OP_INV,
    OP_TERM,
    OP_READ,
    OP_READ_NULL
  } op_t;

  typedef struct packed {
    op_t          op;
    logic [11:0]  entry;
    logic [9:0]   step;
    logic [7:0]   species;
    logic [63:0]  data;
  } item_t;

endpackage

`default_nettype wire

/* rtl/sjsa_ram.sv */
// ----------------------------------------------------------------------------
// sjsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sjsa_front.sv */
// ----------------------------------------------------------------------------
// sjsa_front
// Classify incoming items by mode and index range, queue them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sjsa_front import sjsa_pkg::*; #(
  parameter int NUM_STEPS   = 1024,
  parameter int NUM_SPECIES = 256,
  parameter int NUM_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic [1:0]  mode,
  input  wire logic [11:0] entry_index,
  input  wire logic [9:0]  step_index,
  input  wire logic [7:0]  species_index,
  input  wire logic [63:0] data_value,
  output logic             full,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        pop
);

  logic  step_ok, spec_ok, entry_ok, keep;
  item_t cls;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    step_ok  = 32'(step_index) < NUM_STEPS;
    spec_ok  = 32'(species_index) < NUM_SPECIES;
    entry_ok = 32'(entry_index) < NUM_ENTRIES;
    cls.entry   = entry_index;
    cls.step    = step_index;
    cls.species = species_index;
    cls.data    = data_value;
    cls.op      = OP_READ_NULL;
    keep        = 1'b1;
    case (mode)
      MODE_RATE: begin
        cls.op = OP_RATE;
        keep   = step_ok;
      end
      MODE_INV: begin
        cls.op = OP_INV;
        keep   = spec_ok;
      end
      MODE_TERM: begin
        cls.op = OP_TERM;
        keep   = step_ok && spec_ok && entry_ok;
      end
      MODE_READ: begin
        cls.op = entry_ok ? OP_READ : OP_READ_NULL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign do_push    = push && keep;
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/sjsa_back.sv */
// ----------------------------------------------------------------------------
// sjsa_back
// Carry out queued items: store loads, term multiply-accumulate, entry reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sjsa_back import sjsa_pkg::*; #(
  parameter int NUM_STEPS   = 1024,
  parameter int NUM_SPECIES = 256,
  parameter int NUM_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             pop,
  output logic             clearing,
  output logic             out_strobe,
  output logic [63:0]      out_entry_value,
  output logic             out_saturated
);

  localparam int RAW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int IAW = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int EAW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [EAW-1:0] LAST_ENTRY = EAW'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_FIN, S_SET2, S_ADD, S_RDOUT
  } state_t;

  state_t         state_r, state_nxt;
  item_t          item_r;
  logic           clr_r;
  logic [EAW-1:0] clr_cnt_r;
  logic [64:0]    jac_r;
  logic [63:0]    inv_r, res_r;
  logic [63:0]    ma_r, mb_r;
  logic           neg_r, second_r, sat_r;
  logic [127:0]   acc_r;
  logic [1:0]     cnt_r;
  logic           ov_r;
  logic [63:0]    ov_val_r;
  logic           ov_sat_r;

  logic [RAW+9:0]  step_ext_q, step_ext_r;
  logic [IAW+7:0]  spec_ext_q, spec_ext_r;
  logic [EAW+11:0] ent_ext_q, ent_ext_r;

  logic           rate_we, inv_we, rate_re, inv_re, jac_re, jac_we_op, jac_we;
  logic [63:0]    rate_rdata, inv_rdata;
  logic [64:0]    jac_rdata, jac_wdata_op, jac_wdata;
  logic [EAW-1:0] jac_raddr, jac_waddr;
  logic [RAW-1:0] rate_addr;
  logic [IAW-1:0] inv_addr;

  logic [63:0]    set_a, set_b;
  logic           do_set;
  logic [31:0]    op_a, op_b;
  logic [63:0]    pp;
  logic [127:0]   pp_sh;
  logic [95:0]    qv;
  logic [63:0]    limit, fin_res;
  logic           fin_ovf;
  logic [63:0]    sum;
  logic           add_ovf;
  logic [63:0]    add_res;
  logic           ov_nxt;

  assign step_ext_q = {{RAW{1'b0}}, q_item.step};
  assign spec_ext_q = {{IAW{1'b0}}, q_item.species};
  assign ent_ext_q  = {{EAW{1'b0}}, q_item.entry};
  assign step_ext_r = {{RAW{1'b0}}, item_r.step};
  assign spec_ext_r = {{IAW{1'b0}}, item_r.species};
  assign ent_ext_r  = {{EAW{1'b0}}, item_r.entry};

  assign pop       = (state_r == S_IDLE) && !clr_r && q_valid;
  assign clearing  = clr_r;
  assign rate_addr = pop ? step_ext_q[RAW-1:0] : step_ext_r[RAW-1:0];
  assign inv_addr  = pop ? spec_ext_q[IAW-1:0] : spec_ext_r[IAW-1:0];
  assign rate_we   = pop && (q_item.op == OP_RATE);
  assign inv_we    = pop && (q_item.op == OP_INV);
  assign rate_re   = pop && (q_item.op == OP_TERM);
  assign inv_re    = rate_re;
  assign jac_re    = pop && ((q_item.op == OP_TERM) || (q_item.op == OP_READ));
  assign jac_raddr = ent_ext_q[EAW-1:0];

  // multiplier datapath
  always_comb begin
    op_a = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    op_b = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp   = 64'(op_a) * 64'(op_b);
    case (cnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    qv      = acc_r[127:32] + {95'd0, (neg_r && (acc_r[31:0] != 32'd0))};
    limit   = neg_r ? Q_MIN : Q_MAX;
    fin_ovf = (qv[95:64] != 32'd0) || (qv[63:0] > limit);
    fin_res = fin_ovf ? limit : (neg_r ? (64'd0 - qv[63:0]) : qv[63:0]);
    sum     = jac_r[63:0] + res_r;
    add_ovf = (jac_r[63] == res_r[63]) && (sum[63] != jac_r[63]);
    add_res = add_ovf ? (jac_r[63] ? Q_MIN : Q_MAX) : sum;
  end

  always_comb begin
    state_nxt    = state_r;
    do_set       = 1'b0;
    set_a        = item_r.data;
    set_b        = rate_rdata;
    jac_we_op    = 1'b0;
    jac_wdata_op = '0;
    ov_nxt       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          case (q_item.op)
            OP_TERM:      state_nxt = S_RD;
            OP_READ:      state_nxt = S_RDOUT;
            OP_READ_NULL: ov_nxt    = 1'b1;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        do_set    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cnt_r == 2'd3) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = second_r ? S_ADD : S_SET2;
      end
      S_SET2: begin
        do_set    = 1'b1;
        set_a     = res_r;
        set_b     = inv_r;
        state_nxt = S_MUL;
      end
      S_ADD: begin
        jac_we_op    = 1'b1;
        jac_wdata_op = {jac_r[64] | sat_r | add_ovf, add_res};
        state_nxt    = S_IDLE;
      end
      S_RDOUT: begin
        ov_nxt       = 1'b1;
        jac_we_op    = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (clr_r) begin
      jac_we    = 1'b1;
      jac_waddr = clr_cnt_r;
      jac_wdata = '0;
    end else begin
      jac_we    = jac_we_op;
      jac_waddr = ent_ext_r[EAW-1:0];
      jac_wdata = jac_wdata_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + EAW'(1);
        if (clr_cnt_r == LAST_ENTRY) begin
          clr_r <= 1'b0;
        end
      end
    end
    if (ov_nxt) begin
      ov_val_r <= (state_r == S_RDOUT) ? jac_rdata[63:0] : 64'd0;
      ov_sat_r <= (state_r == S_RDOUT) && jac_rdata[64];
    end
    if (pop) begin
      item_r <= q_item;
    end
    if (state_r == S_RD) begin
      jac_r    <= jac_rdata;
      inv_r    <= inv_rdata;
      sat_r    <= 1'b0;
      second_r <= 1'b0;
    end
    if (state_r == S_SET2) begin
      second_r <= 1'b1;
    end
    if (do_set) begin
      neg_r <= set_a[63] ^ set_b[63];
      ma_r  <= set_a[63] ? (64'd0 - set_a) : set_a;
      mb_r  <= set_b[63] ? (64'd0 - set_b) : set_b;
      acc_r <= '0;
      cnt_r <= 2'd0;
    end else if (state_r == S_MUL) begin
      acc_r <= acc_r + pp_sh;
      cnt_r <= cnt_r + 2'd1;
    end
    if (state_r == S_FIN) begin
      res_r <= fin_res;
      if (fin_ovf) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign out_strobe      = ov_r;
  assign out_entry_value = ov_val_r;
  assign out_saturated   = ov_sat_r;

  sjsa_ram #(.WIDTH(64), .DEPTH(NUM_STEPS)) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (rate_addr),
    .wdata (q_item.data),
    .re    (rate_re),
    .raddr (rate_addr),
    .rdata (rate_rdata)
  );

  sjsa_ram #(.WIDTH(64), .DEPTH(NUM_SPECIES)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_addr),
    .wdata (q_item.data),
    .re    (inv_re),
    .raddr (inv_addr),
    .rdata (inv_rdata)
  );

  sjsa_ram #(.WIDTH(65), .DEPTH(NUM_ENTRIES)) u_jac_ram (
    .clk   (clk),
    .we    (jac_we),
    .waddr (jac_waddr),
    .wdata (jac_wdata),
    .re    (jac_re),
    .raddr (jac_raddr),
    .rdata (jac_rdata)
  );

endmodule

`default_nettype wire

/* rtl/sparse_jacobian_scatter_accumulate.sv */
// ----------------------------------------------------------------------------
// sparse_jacobian_scatter_accumulate
// Weighted sparse scatter-accumulate into a Q32.32 Jacobian store.
//
//   channel  ports                          handshake
//   input    in_mode .. in_data_value       start high, busy low
//   result   out_entry_value, out_saturated out_strobe, one cycle
//
// In the back end a load is written as it is popped; a read passes S_RDOUT; a term
// does three reads, two 64x64 multiplies as four 32x32 partial products each
// on one shared multiplier, saturation, add and write back.
// After reset, busy stays high while all NUM_ENTRIES entries of the Jacobian
// store are swept to zero. busy also rises when the two-item queue is full.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_jacobian_scatter_accumulate import sjsa_pkg::*; #(
  parameter int NUM_STEPS   = 1024,
  parameter int NUM_SPECIES = 256,
  parameter int NUM_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [11:0] in_entry_index,
  input  wire logic [9:0]  in_step_index,
  input  wire logic [7:0]  in_species_index,
  input  wire logic [63:0] in_data_value,
  output logic             out_strobe,
  output logic [63:0]      out_entry_value,
  output logic             out_saturated
);

  logic  full, q_valid, pop, clearing;
  item_t q_item;

  assign busy = full || clearing;

  sjsa_front #(
    .NUM_STEPS   (NUM_STEPS),
    .NUM_SPECIES (NUM_SPECIES),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (start && !busy),
    .mode          (in_mode),
    .entry_index   (in_entry_index),
    .step_index    (in_step_index),
    .species_index (in_species_index),
    .data_value    (in_data_value),
    .full          (full),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop)
  );

  sjsa_back #(
    .NUM_STEPS   (NUM_STEPS),
    .NUM_SPECIES (NUM_SPECIES),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .clearing        (clearing),
    .out_strobe      (out_strobe),
    .out_entry_value (out_entry_value),
    .out_saturated   (out_saturated)
  );

endmodule

`default_nettype wire

/* rtl/sjsa_checker.sv */
// ----------------------------------------------------------------------------
// sjsa_checker
// Port-level checks on the scatter-accumulate top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sjsa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_strobe
);

  `SJSA_ASSERT_IMP(a_busy_after_reset, clk, rst_n, $past(!rst_n), busy, "not busy after reset")
  `SJSA_ASSERT_IMP(a_no_result_after_reset, clk, rst_n, $past(!rst_n), !out_strobe, "result after reset")
  `SJSA_ASSERT_IMP(a_result_needs_history, clk, rst_n, out_strobe, $past(rst_n) && $past(rst_n, 2), "result too soon")

endmodule

bind sparse_jacobian_scatter_accumulate sjsa_checker u_sjsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe)
);

`default_nettype wire
